// File: rtl/core/keyframe_catmull_rom_player_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyframe player
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_CATMULL_ROM_PLAYER_DEFINES_SVH
`define KEYFRAME_CATMULL_ROM_PLAYER_DEFINES_SVH

`ifndef SYNTH
`define KCR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcr assertion failed");
`define KCR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcr assertion failed");
`else
`define KCR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KCR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/kcr_pkg.sv
// ---------------------------------------------------------------------------
// Keyframe player package
// Sizes, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package kcr_pkg;

   localparam int KEYFRAMES     = 4;
   localparam int FRAC_BITS     = 16;
   localparam int WORDS_PER_KEY = 10;
   localparam int NUM_CH        = 9;
   localparam int DUR_CH        = 9;

   localparam int KEY_W   = $clog2(KEYFRAMES);
   localparam int DEPTH   = KEYFRAMES * WORDS_PER_KEY;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CH_W    = 4;
   localparam int DIV_W   = 32 + FRAC_BITS;
   localparam int P_W     = DIV_W + 1;
   localparam int F_W     = FRAC_BITS + 1;
   localparam int E_W     = 36;
   localparam int ACC_W   = 40;
   localparam int PROD_W  = ACC_W + F_W + 1;
   localparam int CNT_W   = $clog2(DIV_W + 1);
   localparam int STEP_W  = 2;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 296;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] STEP_E2 = 2'd0;
   localparam logic [1:0] STEP_E1 = 2'd1;
   localparam logic [1:0] STEP_E0 = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_DUR,
      ST_DIV_INIT,
      ST_DIV,
      ST_SEG,
      ST_RD,
      ST_EVAL,
      ST_MUL,
      ST_ADD,
      ST_STORE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              clear_res;
      logic              load_word;
      logic              start;
      logic              tick_begin;
      logic              rd_en;
      logic              rd_dur;
      logic [1:0]        rd_pt;
      logic              div_init;
      logic              div_step;
      logic              seg_calc;
      logic              eval;
      logic              mul;
      logic              add;
      logic [STEP_W-1:0] step;
      logic              store;
      logic [CH_W-1:0]   chan;
      logic              finish;
   } cmd_type;

   typedef struct packed {
      logic active;
   } status_type;

endpackage

// File: rtl/core/kcr_datapath.sv
// ---------------------------------------------------------------------------
// Keyframe player datapath
// Keyframe memory, playback state, restoring divider and Horner evaluator.
// ---------------------------------------------------------------------------
module kcr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  kcr_pkg::cmd_type    cmd,
   output kcr_pkg::status_type status,
   input  logic [1:0]          key_slot,
   input  logic [3:0]          channel,
   input  logic signed [31:0]  value,
   input  logic [30:0]         delta_time,
   output logic signed [31:0]  res_out [kcr_pkg::NUM_CH],
   output logic                playing,
   output logic [1:0]          segment_out
);
   import kcr_pkg::*;

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;
   logic               rd_en_ff, rd_dur_ff;
   logic [1:0]         rd_pt_ff;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [KEY_W-1:0]   idx;

   logic               active_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [31:0]        elapsed_ff;
   logic [32:0]        sum;

   logic signed [31:0] dur_ff;
   logic signed [31:0] pt_ff [4];
   logic [31:0]        dv_ff;
   logic [32:0]        rem_ff, rs;
   logic [DIV_W-1:0]   quo_ff;
   logic               ge;
   logic [P_W-1:0]     p, lim;
   logic [KEY_W-1:0]   seg_ff;
   logic [F_W-1:0]     f_ff;

   logic signed [E_W-1:0]    s0, s1, s2, s3;
   logic signed [E_W-1:0]    e2_ff, e1_ff, e0_ff;
   logic signed [ACC_W-1:0]  acc_ff, addend, half;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [31:0]       res_ff [NUM_CH];

   // memory
   always_comb begin
      case (cmd.rd_pt)
         2'd0:    idx = (seg_ff == '0) ? seg_ff : seg_ff - 1'b1;
         2'd1:    idx = seg_ff;
         2'd2:    idx = seg_ff + 1'b1;
         default: idx = (32'(seg_ff) + 2 >= KEYFRAMES) ? seg_ff + 1'b1 : seg_ff + KEY_W'(2);
      endcase
      if (cmd.rd_dur)
         rd_addr = ADDR_W'(32'(key_ff) * WORDS_PER_KEY + DUR_CH);
      else
         rd_addr = ADDR_W'(32'(idx) * WORDS_PER_KEY + 32'(cmd.chan));
      wr_addr = ADDR_W'(32'(key_slot) * WORDS_PER_KEY + 32'(channel));
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word && 32'(key_slot) < KEYFRAMES && 32'(channel) < WORDS_PER_KEY)
         mem[wr_addr] <= value;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd.rd_en;
      end
      rd_dur_ff <= cmd.rd_dur;
      rd_pt_ff  <= cmd.rd_pt;
      if (rd_en_ff) begin
         if (rd_dur_ff)
            dur_ff <= rdata_ff;
         else
            pt_ff[rd_pt_ff] <= rdata_ff;
      end
   end

   // playback state
   assign sum = {1'b0, elapsed_ff} + {2'b00, delta_time};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         key_ff     <= '0;
         elapsed_ff <= '0;
      end else if (cmd.start) begin
         active_ff  <= 1'b1;
         key_ff     <= '0;
         elapsed_ff <= '0;
      end else if (cmd.tick_begin) begin
         elapsed_ff <= sum[32] ? '1 : sum[31:0];
      end else if (cmd.finish &&
                   $signed({1'b0, elapsed_ff}) >= $signed({dur_ff[31], dur_ff})) begin
         if (32'(key_ff) >= KEYFRAMES - 1) begin
            active_ff <= 1'b0;
         end else begin
            key_ff     <= key_ff + 1'b1;
            elapsed_ff <= '0;
         end
      end
   end

   assign status.active = active_ff;

   // divider
   assign rs = {rem_ff[31:0], quo_ff[DIV_W-1]};
   assign ge = rs >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dv_ff  <= (dur_ff > 0) ? dur_ff : 32'(1) << FRAC_BITS;
         rem_ff <= '0;
         quo_ff <= DIV_W'(elapsed_ff) << FRAC_BITS;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? rs - {1'b0, dv_ff} : rs;
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   // segment and fraction
   assign p   = (P_W'(key_ff) << FRAC_BITS) + P_W'(quo_ff);
   assign lim = P_W'(KEYFRAMES - 1) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (cmd.clear_res) begin
         seg_ff <= '0;
      end else if (cmd.seg_calc) begin
         if (p >= lim) begin
            seg_ff <= KEY_W'(KEYFRAMES - 2);
            f_ff   <= F_W'(1) << FRAC_BITS;
         end else begin
            seg_ff <= KEY_W'(p >> FRAC_BITS);
            f_ff   <= {1'b0, p[FRAC_BITS-1:0]};
         end
      end
   end

   // Horner evaluation
   assign s0 = E_W'(pt_ff[0]);
   assign s1 = E_W'(pt_ff[1]);
   assign s2 = E_W'(pt_ff[2]);
   assign s3 = E_W'(pt_ff[3]);

   always_comb begin
      case (cmd.step)
         STEP_E2: addend = ACC_W'(e2_ff);
         STEP_E1: addend = ACC_W'(e1_ff);
         STEP_E0: addend = ACC_W'(e0_ff);
         default: addend = '0;
      endcase
   end

   assign half = acc_ff >>> 1;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         acc_ff <= ACC_W'(s3 - s0 + 3 * s1 - 3 * s2);
         e2_ff  <= 2 * s0 - 5 * s1 + 4 * s2 - s3;
         e1_ff  <= s2 - s0;
         e0_ff  <= 2 * s1;
      end else if (cmd.add) begin
         acc_ff <= ACC_W'(prod_ff >>> FRAC_BITS) + addend;
      end
      if (cmd.mul)
         prod_ff <= PROD_W'(acc_ff) * PROD_W'($signed({1'b0, f_ff}));
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_res) begin
         for (int i = 0; i < NUM_CH; i++)
            res_ff[i] <= '0;
      end else if (cmd.store) begin
         if (half > ACC_W'(32'sh7FFFFFFF))
            res_ff[cmd.chan] <= 32'sh7FFFFFFF;
         else if (half < -ACC_W'(33'sh080000000))
            res_ff[cmd.chan] <= 32'sh80000000;
         else
            res_ff[cmd.chan] <= half[31:0];
      end
   end

   assign res_out     = res_ff;
   assign playing     = active_ff;
   assign segment_out = seg_ff[1:0];

endmodule

// File: rtl/core/kcr_ctrl.sv
// ---------------------------------------------------------------------------
// Keyframe player controller
// Sequences divide, point reads and the nine channel evaluations.
// ---------------------------------------------------------------------------
`include "keyframe_catmull_rom_player_defines.svh"

module kcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          op,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output kcr_pkg::cmd_type    cmd,
   input  kcr_pkg::status_type status
);
   import kcr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   logic             valid_ff, valid_in;
   logic             accept, tick_go;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign tick_go    = accept && op == OP_TICK && status.active;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (tick_go)
               state_in = ST_RD_DUR;
         end
         ST_RD_DUR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(1))
               state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1))
               state_in = ST_SEG;
         end
         ST_SEG: begin
            cnt_in   = '0;
            chan_in  = '0;
            state_in = ST_RD;
         end
         ST_RD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(4))
               state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == CNT_W'(STEP_E0)) ? ST_STORE : ST_MUL;
         end
         ST_STORE: begin
            cnt_in = '0;
            if (chan_ff == CH_W'(NUM_CH - 1)) begin
               state_in = ST_FINISH;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.chan       = chan_ff;
      cmd.step       = cnt_ff[STEP_W-1:0];
      cmd.rd_pt      = cnt_ff[1:0];
      valid_in       = valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_word  = op == OP_LOAD;
               cmd.start      = op == OP_START;
               cmd.tick_begin = tick_go;
               cmd.clear_res  = !tick_go;
               valid_in       = !tick_go;
            end
         end
         ST_RD_DUR: begin
            cmd.rd_en  = cnt_ff == '0;
            cmd.rd_dur = 1'b1;
         end
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_SEG:      cmd.seg_calc = 1'b1;
         ST_RD:       cmd.rd_en    = cnt_ff < CNT_W'(4);
         ST_EVAL:     cmd.eval     = 1'b1;
         ST_MUL:      cmd.mul      = 1'b1;
         ST_ADD:      cmd.add      = 1'b1;
         ST_STORE:    cmd.store    = 1'b1;
         ST_FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         chan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   `KCR_ASSERT_IMP(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `KCR_ASSERT_IMP(a_div_bound, clock, reset, state_ff == ST_DIV, cnt_ff < CNT_W'(DIV_W))
   `KCR_ASSERT_NXT(a_tick_no_early_rsp, clock, reset, tick_go, !rsp_tvalid)
   `KCR_ASSERT_IMP(a_chan_bound, clock, reset, state_ff != ST_IDLE, chan_ff < CH_W'(NUM_CH))

endmodule

// File: rtl/core/keyframe_catmull_rom_player.sv
// ---------------------------------------------------------------------------
// Keyframe Catmull-Rom player
// Top level: stream ports, controller and datapath.
// ---------------------------------------------------------------------------
// Load and start items, and ticks on an inactive player, answer with a
// registered response. A tick on an active player reads the duration, runs
// the 48-step restoring divide of elapsed by duration, finds the segment,
// then per channel reads the points from the keyframe memory through its
// one read port, forms the coefficients, runs three multiply/add steps and
// stores the result, for all 9 channels, then updates playback. One result
// per item; the next item is taken while the previous result is being transferred.
module keyframe_catmull_rom_player (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // key_slot[1:0], channel[5:2], value[37:6], delta_time[68:38], zero pad
   input  logic [kcr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // op[1:0]
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pos_x..scale_z 32 bits each from bit 0, playing[288], segment_out[290:289]
   output logic [kcr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import kcr_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic signed [31:0] res [NUM_CH];
   logic               playing;
   logic [1:0]         segment_out;

   kcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   kcr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .key_slot    (req_tdata[1:0]),
      .channel     (req_tdata[5:2]),
      .value       (req_tdata[37:6]),
      .delta_time  (req_tdata[68:38]),
      .res_out     (res),
      .playing     (playing),
      .segment_out (segment_out)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NUM_CH; i++)
         rsp_tdata[i*32 +: 32] = res[i];
      rsp_tdata[288]     = playing;
      rsp_tdata[290:289] = segment_out;
   end

endmodule
